/* src/mon_pkg.sv */
package mon_pkg;

    // Fixed point and field widths.
    localparam int FRAC_BITS = 8;
    localparam int IN_W      = 16;
    localparam int VAL_W     = 25;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int AXES      = 3;
    localparam int AX_W      = 2;
    localparam int RATE_FRAC = 16;

    // Internal arithmetic widths.
    localparam int D_W    = VAL_W + 1;
    localparam int MUL_W  = D_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 2 * D_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int Q_W    = RATE_FRAC + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] MIN_STEP_RESET = CFG_W'(50);

    typedef enum logic {
        UM_ROOT = 1'b0,
        UM_DIV  = 1'b1
    } t_unit_mode;

    typedef struct packed {
        logic       start;
        t_unit_mode mode;
    } t_unit_ctrl;

endpackage

/* src/mon_in_if.sv */
interface mon_in_if import mon_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] field_x;
    logic signed [IN_W-1:0] field_y;
    logic signed [IN_W-1:0] field_z;

    modport source (output valid, output field_x, output field_y, output field_z,
                    input ready);
    modport sink   (input valid, input field_x, input field_y, input field_z,
                    output ready);
endinterface

/* src/mon_out_if.sv */
interface mon_out_if import mon_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] corrected_x;
    logic signed [VAL_W-1:0] corrected_y;
    logic signed [VAL_W-1:0] corrected_z;
    logic signed [VAL_W-1:0] offset_x;
    logic signed [VAL_W-1:0] offset_y;
    logic signed [VAL_W-1:0] offset_z;
    logic                    offset_changed;

    modport source (output valid, output corrected_x, output corrected_y, output corrected_z,
                    output offset_x, output offset_y, output offset_z,
                    output offset_changed, input ready);
    modport sink   (input valid, input corrected_x, input corrected_y, input corrected_z,
                    input offset_x, input offset_y, input offset_z,
                    input offset_changed, output ready);
endinterface

/* src/mag_offset_nulling.sv */
// Channel   Direction  Beat contents
// i_in      in         field_x, field_y, field_z (16 bit signed sensor units)
// o_out     out        corrected_x/y/z, offset_x/y/z (25 bit, 8 fraction bits),
//                      offset_changed
// i_cfg_*   in         write enable, register index, 16 bit data (rate, min step)
//
// One sample is taken at a time; ready is high only while the sequencer is idle.
// With nulling off, or when the sample only becomes the first reference, the result
// is registered directly after the path state; a step at or below the threshold is
// registered after its squared step is compared with the squared threshold. A bias update
// adds three square roots (26 steps each) and a divide (19 steps) in the shared root/divide unit.
// The next sample can be taken in the cycle after its predecessor's result is
// registered. The result sits in an output register; a result still waiting for
// the sink holds the next sample in its final state.
// Reset is synchronous and clears state, configuration, bias, reference and output
// valid to their defaults; no clearing pass is needed.
module mag_offset_nulling import mon_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    mon_in_if.sink               i_in,
    mon_out_if.source            o_out
);

    localparam int SAMP_W = IN_W + FRAC_BITS;
    localparam int EXT_W  = 40;
    localparam int TM_W   = PROD_W - RATE_FRAC;

    localparam logic signed [EXT_W-1:0] VAL_HI = EXT_W'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] VAL_LO = -VAL_HI - EXT_W'(1);
    localparam logic [PROD_W-1:0]       ROUND_HALF = PROD_W'(1) << (RATE_FRAC - 1);

    // Which vector the square/accumulate pass works on, and which root it feeds.
    localparam logic [AX_W-1:0] PASS_D    = AX_W'(0);
    localparam logic [AX_W-1:0] PASS_REF  = AX_W'(1);
    localparam logic [AX_W-1:0] PASS_CORR = AX_W'(2);
    localparam logic [AX_W-1:0] LAST_AX   = AX_W'(AXES - 1);

    typedef enum logic [13:0] {
        ST_IDLE       = 14'b00000000000001,
        ST_PATH       = 14'b00000000000010,
        ST_SQ_ISSUE   = 14'b00000000000100,
        ST_SQ_ACC     = 14'b00000000001000,
        ST_LIM_ISSUE  = 14'b00000000010000,
        ST_LIM_CMP    = 14'b00000000100000,
        ST_ROOT_START = 14'b00000001000000,
        ST_ROOT_WAIT  = 14'b00000010000000,
        ST_RATE_ISSUE = 14'b00000100000000,
        ST_RATE_TAKE  = 14'b00001000000000,
        ST_DIV_WAIT   = 14'b00010000000000,
        ST_TERM_ISSUE = 14'b00100000000000,
        ST_TERM_ADD   = 14'b01000000000000,
        ST_DONE       = 14'b10000000000000
    } t_state;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] c;
        c = v;
        if (v > VAL_HI) begin
            c = VAL_HI;
        end else if (v < VAL_LO) begin
            c = VAL_LO;
        end
        return c[VAL_W-1:0];
    endfunction

    t_state                   r_state;
    logic [CFG_W-1:0]         r_rate;
    logic [CFG_W-1:0]         r_min;
    logic signed [VAL_W-1:0]  r_bias [AXES];
    logic signed [VAL_W-1:0]  r_ref  [AXES];
    logic signed [VAL_W-1:0]  r_corr [AXES];
    logic signed [D_W-1:0]    r_d    [AXES];
    logic [SQ_W-1:0]          r_ss   [AXES];
    logic [ROOT_W-1:0]        r_root [AXES];
    logic [SQ_W-1:0]          r_acc;
    logic [AX_W-1:0]          r_ax;
    logic [AX_W-1:0]          r_pass;
    logic                     r_qneg;
    logic signed [Q_W-1:0]    r_s;
    logic                     r_chg;

    logic                     r_ov;
    logic signed [VAL_W-1:0]  r_out_corr [AXES];
    logic signed [VAL_W-1:0]  r_out_off  [AXES];
    logic                     r_out_chg;

    logic signed [IN_W-1:0]   w_field   [AXES];
    logic signed [SAMP_W-1:0] w_samp    [AXES];
    logic signed [VAL_W-1:0]  w_corr_in [AXES];
    logic                     w_ref_zero;

    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [D_W-1:0]    w_sq_op;
    logic signed [MUL_W-1:0]  w_ndiff;
    logic [PROD_W-1:0]        w_pmag;
    logic [PROD_W-1:0]        w_prnd;
    logic [TM_W-1:0]          w_tmag;
    logic signed [EXT_W-1:0]  w_term;
    logic signed [VAL_W-1:0]  w_bias_new;

    t_unit_ctrl               w_uctrl;
    logic [SQ_W-1:0]          w_uopa;
    logic [ROOT_W-1:0]        w_uopb;
    logic                     w_done;
    logic [ROOT_W-1:0]        w_res;
    logic [Q_W-1:0]           w_q;

    assign w_field[0] = i_in.field_x;
    assign w_field[1] = i_in.field_y;
    assign w_field[2] = i_in.field_z;

    // Corrected sample: the input moved to fixed point, minus the old bias
    // when nulling is enabled, saturated to the output width.
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_samp[k] = $signed({w_field[k], {FRAC_BITS{1'b0}}});
            if (r_rate == '0) begin
                w_corr_in[k] = VAL_W'(w_samp[k]);
            end else begin
                w_corr_in[k] = sat_val(EXT_W'(w_samp[k]) - EXT_W'(r_bias[k]));
            end
        end
    end

    // An all-zero reference means no reference has been captured yet.
    assign w_ref_zero = (r_ref[0] == '0) && (r_ref[1] == '0) && (r_ref[2] == '0);

    always_comb begin
        case (r_pass)
            PASS_D:    w_sq_op = r_d[r_ax];
            PASS_REF:  w_sq_op = D_W'(r_ref[r_ax]);
            PASS_CORR: w_sq_op = D_W'(r_corr[r_ax]);
            default:   w_sq_op = '0;
        endcase
    end

    // Difference of the reference norm and the sample norm.
    assign w_ndiff = $signed({1'b0, r_root[PASS_REF]}) - $signed({1'b0, r_root[PASS_CORR]});

    // The shared multiplier squares vector components, forms the squared
    // threshold, scales the norm difference by the rate and forms each bias term.
    always_comb begin
        unique case (r_state)
            ST_SQ_ISSUE: begin
                w_mul_a = MUL_W'(w_sq_op);
                w_mul_b = MUL_W'(w_sq_op);
            end
            ST_LIM_ISSUE: begin
                w_mul_a = $signed(MUL_W'({r_min, {FRAC_BITS{1'b0}}}));
                w_mul_b = $signed(MUL_W'({r_min, {FRAC_BITS{1'b0}}}));
            end
            ST_RATE_ISSUE: begin
                w_mul_a = $signed(MUL_W'(r_rate));
                w_mul_b = w_ndiff;
            end
            ST_TERM_ISSUE: begin
                w_mul_a = MUL_W'(r_d[r_ax]);
                w_mul_b = MUL_W'(r_s);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mon_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Magnitude of the registered product: the divide works on it, and the
    // bias term rounds it to nearest with halves away from zero.
    assign w_pmag     = w_prod[PROD_W-1] ? PROD_W'(-w_prod) : PROD_W'(w_prod);
    assign w_prnd     = w_pmag + ROUND_HALF;
    assign w_tmag     = w_prnd[PROD_W-1:RATE_FRAC];
    assign w_term     = w_prod[PROD_W-1] ? -$signed(EXT_W'(w_tmag)) : $signed(EXT_W'(w_tmag));
    assign w_bias_new = sat_val(EXT_W'(r_bias[r_ax]) + w_term);

    always_comb begin
        w_uctrl.start = 1'b0;
        w_uctrl.mode  = UM_ROOT;
        w_uopa        = r_ss[r_pass];
        w_uopb        = r_root[PASS_D];
        if (r_state == ST_ROOT_START) begin
            w_uctrl.start = 1'b1;
        end else if (r_state == ST_RATE_TAKE) begin
            w_uctrl.start = 1'b1;
            w_uctrl.mode  = UM_DIV;
            w_uopa        = w_pmag[SQ_W-1:0];
        end
    end

    mon_sqdiv u_sqdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_uctrl),
        .i_opa    (w_uopa),
        .i_opb    (w_uopb),
        .o_done   (w_done),
        .o_result (w_res)
    );

    assign w_q = w_res[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rate  <= '0;
            r_min   <= MIN_STEP_RESET;
            r_ov    <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_bias[k] <= '0;
                r_ref[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE: r_rate <= i_cfg_wdata;
                    CFG_MIN:  r_min  <= i_cfg_wdata;
                endcase
            end

            // The output register refills from the final state, which may happen at
            // the same edge as the sink takes the beat it holds.
            if (r_state == ST_DONE && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_corr[k] <= w_corr_in[k];
                        end
                        r_state <= ST_PATH;
                    end
                end
                ST_PATH: begin
                    r_chg  <= 1'b0;
                    r_ax   <= '0;
                    r_pass <= PASS_D;
                    r_acc  <= '0;
                    for (int k = 0; k < AXES; k++) begin
                        r_d[k] <= D_W'(r_ref[k]) - D_W'(r_corr[k]);
                    end
                    if (r_rate == '0) begin
                        r_state <= ST_DONE;
                    end else if (w_ref_zero) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_ref[k] <= r_corr[k];
                        end
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SQ_ISSUE;
                    end
                end
                ST_SQ_ISSUE: begin
                    r_state <= ST_SQ_ACC;
                end
                ST_SQ_ACC: begin
                    if (r_ax == LAST_AX) begin
                        r_ss[r_pass] <= r_acc + w_prod[SQ_W-1:0];
                        r_acc        <= '0;
                        r_ax         <= '0;
                        if (r_pass == PASS_D) begin
                            r_state <= ST_LIM_ISSUE;
                        end else if (r_pass == PASS_REF) begin
                            r_pass  <= PASS_CORR;
                            r_state <= ST_SQ_ISSUE;
                        end else begin
                            r_pass  <= PASS_D;
                            r_state <= ST_ROOT_START;
                        end
                    end else begin
                        r_acc   <= r_acc + w_prod[SQ_W-1:0];
                        r_ax    <= r_ax + AX_W'(1);
                        r_state <= ST_SQ_ISSUE;
                    end
                end
                ST_LIM_ISSUE: begin
                    r_state <= ST_LIM_CMP;
                end
                ST_LIM_CMP: begin
                    // Squares are compared exactly, so no rounded root enters the test.
                    if (r_ss[PASS_D] > w_prod[SQ_W-1:0]) begin
                        r_pass  <= PASS_REF;
                        r_state <= ST_SQ_ISSUE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_ROOT_START: begin
                    r_state <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT: begin
                    if (w_done) begin
                        r_root[r_pass] <= w_res;
                        if (r_pass == PASS_CORR) begin
                            r_state <= ST_RATE_ISSUE;
                        end else begin
                            r_pass  <= r_pass + AX_W'(1);
                            r_state <= ST_ROOT_START;
                        end
                    end
                end
                ST_RATE_ISSUE: begin
                    r_state <= ST_RATE_TAKE;
                end
                ST_RATE_TAKE: begin
                    r_qneg  <= w_prod[PROD_W-1];
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (w_done) begin
                        // Quotient of the magnitudes, signed afterwards: truncation
                        // goes toward zero.
                        r_s     <= r_qneg ? $signed(Q_W'(-w_q)) : $signed(w_q);
                        r_ax    <= '0;
                        r_state <= ST_TERM_ISSUE;
                    end
                end
                ST_TERM_ISSUE: begin
                    r_state <= ST_TERM_ADD;
                end
                ST_TERM_ADD: begin
                    r_bias[r_ax] <= w_bias_new;
                    if (r_ax == LAST_AX) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_ref[k] <= r_corr[k];
                        end
                        r_chg   <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_ax    <= r_ax + AX_W'(1);
                        r_state <= ST_TERM_ISSUE;
                    end
                end
                ST_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_out_corr[k] <= r_corr[k];
                            r_out_off[k]  <= r_bias[k];
                        end
                        r_out_chg <= r_chg;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);

    assign o_out.valid          = r_ov;
    assign o_out.corrected_x    = r_out_corr[0];
    assign o_out.corrected_y    = r_out_corr[1];
    assign o_out.corrected_z    = r_out_corr[2];
    assign o_out.offset_x       = r_out_off[0];
    assign o_out.offset_y       = r_out_off[1];
    assign o_out.offset_z       = r_out_off[2];
    assign o_out.offset_changed = r_out_chg;

    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == ST_PATH)
        else $error("accepted beat did not start the sequence");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_ROOT_WAIT || r_state == ST_DIV_WAIT))
        else $error("root/divide result arrived outside a wait state");

endmodule

/* src/mon_mul.sv */
module mon_mul import mon_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* src/mon_sqdiv.sv */
module mon_sqdiv import mon_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_ctrl        i_ctrl,
    input  logic [SQ_W-1:0]   i_opa,
    input  logic [ROOT_W-1:0] i_opb,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_result
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_unit_mode       r_mode;
    logic [SQ_W-1:0]  r_v;
    logic [SQ_W-1:0]  r_res;
    logic [SQ_W-1:0]  r_bit;

    logic [SQ_W-1:0]  w_b;
    logic             w_ge;
    logic [SQ_W-1:0]  w_diff;

    // One compare and subtract serves both the root digit and the quotient bit.
    assign w_b    = (r_mode == UM_ROOT) ? (r_res + r_bit) : r_bit;
    assign w_ge   = (r_v >= w_b);
    assign w_diff = r_v - w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctrl.mode == UM_ROOT) ? CNT_W'(ROOT_W - 1) : CNT_W'(Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mode <= i_ctrl.mode;
            r_v    <= i_opa;
            r_res  <= '0;
            if (i_ctrl.mode == UM_ROOT) begin
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end else begin
                r_bit <= SQ_W'(i_opb) << (Q_W - 1);
            end
        end else if (r_busy) begin
            if (w_ge) begin
                r_v <= w_diff;
            end
            if (r_mode == UM_ROOT) begin
                r_res <= w_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
                r_bit <= r_bit >> 2;
            end else begin
                r_res <= {r_res[SQ_W-2:0], w_ge};
                r_bit <= r_bit >> 1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res[ROOT_W-1:0];

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> r_busy)
        else $error("unit not busy after start");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("unit done while still busy");

endmodule
